@@ rtl/core/nlt_pkg.sv @@
`timescale 1ns / 1ps
// nlt_pkg: shared types and constants of the name to id lookup table
// used by nlt_match and name_to_id_lookup_table_unit; depends on nothing

package nlt_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int HINT_SLOTS_DEF    = 5;
   localparam int NAME_CHARS_DEF    = 8;

   localparam int MEDIA_CHARS = 2;

   localparam logic KIND_FIND   = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [2:0]  level;
      logic [15:0] media_code;
      logic [63:0] volume_name;
      logic [31:0] record_id;
   } req_type;

   typedef struct packed {
      logic [31:0] result_id;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0] record_id;
      logic [15:0] media_code;
      logic [63:0] volume_name;
   } entry_type;

endpackage

@@ rtl/core/nlt_ram.sv @@
`timescale 1ns / 1ps
// nlt_ram: generic single write port, single read port ram with registered read
// no dependencies

module nlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/nlt_match.sv @@
`timescale 1ns / 1ps
// nlt_match: case-insensitive compare of one stored entry against the request key
// depends on nlt_pkg

module nlt_match #(
   parameter int NAME_CHARS = nlt_pkg::NAME_CHARS_DEF
) (
   input  nlt_pkg::entry_type entry,
   input  logic [15:0]        media_code,
   input  logic [63:0]        volume_name,
   output logic               hit
);

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // stored text a against key b, stops after the first zero character of a
   function automatic logic text_eq(input logic [63:0] a, input logic [63:0] b,
                                    input int nchars);
      logic alive;
      logic ok;
      logic [7:0] ca;
      logic [7:0] cb;
      alive = 1'b1;
      ok    = 1'b1;
      for (int k = 0; k < 8; k++) begin
         ca = a[8*k +: 8];
         cb = b[8*k +: 8];
         if (alive && k < nchars) begin
            if (fold_case(ca) != fold_case(cb)) begin
               ok = 1'b0;
            end
            if (ca == 8'h00) begin
               alive = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   assign hit = text_eq(64'(entry.media_code), 64'(media_code), nlt_pkg::MEDIA_CHARS) &&
                text_eq(entry.volume_name, volume_name, NAME_CHARS);

endmodule

@@ rtl/core/name_to_id_lookup_table_unit.sv @@
`timescale 1ns / 1ps
// name_to_id_lookup_table_unit: top level of the media/volume name to record id table
// depends on nlt_pkg, nlt_ram, nlt_match
//
// usage:
//   a request transfer happens on a clock edge with start high and busy low; the
//   request struct on req_item is taken at that edge. each request gives exactly
//   one result on rsp_item, marked by rsp_strobe for a single cycle; the receiver
//   cannot hold it off.
//   insert: written into the entry ram at the next free slot; result in the cycle
//   after the transfer, busy stays low so a request may follow every cycle.
//   a full table drops the entry and answers id 0 with table_full set.
//   find on an empty table: result in the next cycle, busy stays low.
//   find: busy rises. if the request's level has a hint slot and the entry
//   remembered there lies below the count, it is read and compared first (a hit
//   is answered from the ST_HINT compare). otherwise the entries are read from the
//   ram one per cycle and compared by the single match unit; a find scans at most
//   entry_count <= TABLE_ENTRIES entries; the ram read port and one comparator set the pace.
//   reset clears the entry count, the level hints and the sequencer; the entry
//   ram is not cleared, only slots below the count are ever read.

module name_to_id_lookup_table_unit #(
   parameter int TABLE_ENTRIES = nlt_pkg::TABLE_ENTRIES_DEF,
   parameter int HINT_SLOTS    = nlt_pkg::HINT_SLOTS_DEF,
   parameter int NAME_CHARS    = nlt_pkg::NAME_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nlt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output nlt_pkg::rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int HW = (HINT_SLOTS > 1) ? $clog2(HINT_SLOTS) : 1;
   localparam int EW = $bits(nlt_pkg::entry_type);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HINT = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]       state_ff, state_in;
   nlt_pkg::req_type req_ff, req_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    hint_ff [HINT_SLOTS];
   logic             lvl_ok_ff, lvl_ok_in;
   logic [HW-1:0]    lvl_idx_ff, lvl_idx_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic             dv_ff, dv_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   nlt_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic               accept;
   logic               lvl_ok;
   logic [HW-1:0]      lvl_idx;
   logic [AW-1:0]      hint_sel;
   logic               hint_try;
   logic               hint_we;
   logic               ram_we;
   nlt_pkg::entry_type wr_entry;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [EW-1:0]      rd_raw;
   nlt_pkg::entry_type rd_entry;
   logic               hit;

   assign accept   = start && !busy;
   assign lvl_ok   = 32'(req_item.level) < HINT_SLOTS;
   assign lvl_idx  = HW'(req_item.level);
   assign hint_sel = lvl_ok ? hint_ff[lvl_idx] : '0;
   assign hint_try = lvl_ok && (CW'(hint_sel) < count_ff);

   assign wr_entry.record_id   = req_item.record_id;
   assign wr_entry.media_code  = req_item.media_code;
   assign wr_entry.volume_name = req_item.volume_name;
   assign rd_entry             = nlt_pkg::entry_type'(rd_raw);

   nlt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   nlt_match #(
      .NAME_CHARS (NAME_CHARS)
   ) u_match (
      .entry       (rd_entry),
      .media_code  (req_ff.media_code),
      .volume_name (req_ff.volume_name),
      .hit         (hit)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      lvl_ok_in     = lvl_ok_ff;
      lvl_idx_in    = lvl_idx_ff;
      ptr_in        = ptr_ff;
      dv_in         = dv_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      hint_we       = 1'b0;
      ram_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.kind == nlt_pkg::KIND_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  if (count_ff >= CW'(TABLE_ENTRIES)) begin
                     rsp_item_in.result_id  = '0;
                     rsp_item_in.table_full = 1'b1;
                  end else begin
                     ram_we                 = 1'b1;
                     count_in               = count_ff + CW'(1);
                     rsp_item_in.result_id  = req_item.record_id;
                     rsp_item_in.table_full = 1'b0;
                  end
               end else if (count_ff == '0) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_item_in.result_id  = '0;
                  rsp_item_in.table_full = 1'b0;
               end else begin
                  req_in     = req_item;
                  lvl_ok_in  = lvl_ok;
                  lvl_idx_in = lvl_idx;
                  ptr_in     = '0;
                  dv_in      = 1'b0;
                  if (hint_try) begin
                     rd_en    = 1'b1;
                     rd_addr  = hint_sel;
                     state_in = ST_HINT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_HINT: begin
            if (hit) begin
               rsp_strobe_in          = 1'b1;
               rsp_item_in.result_id  = rd_entry.record_id;
               rsp_item_in.table_full = 1'b0;
               state_in               = ST_IDLE;
            end else begin
               ptr_in   = '0;
               dv_in    = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read address runs one slot ahead of the compare
            priority if (dv_ff && hit) begin
               rsp_strobe_in          = 1'b1;
               rsp_item_in.result_id  = rd_entry.record_id;
               rsp_item_in.table_full = 1'b0;
               hint_we                = lvl_ok_ff;
               state_in               = ST_IDLE;
            end else if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + CW'(1);
               dv_in   = 1'b1;
            end else begin
               dv_in = 1'b0;
               if (!dv_ff) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_item_in.result_id  = '0;
                  rsp_item_in.table_full = 1'b0;
                  state_in               = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot of the entry now on the ram output during the scan
   logic [AW-1:0] cmp_slot;
   assign cmp_slot = ptr_ff[AW-1:0] - AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < HINT_SLOTS; i++) begin
            hint_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dv_ff         <= dv_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (hint_we) begin
            hint_ff[lvl_idx_ff] <= cmp_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      lvl_ok_ff   <= lvl_ok_in;
      lvl_idx_ff  <= lvl_idx_in;
      ptr_ff      <= ptr_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for name_to_id_lookup_table_unit, directed requests then random ones
// depends on nlt_pkg and the unit under test; a scoreboard class predicts every answer

module tb;
   import nlt_pkg::*;

   localparam int DEPTH       = TABLE_ENTRIES_DEF;
   localparam int HINTS       = HINT_SLOTS_DEF;
   localparam int NAME_LEN    = NAME_CHARS_DEF;
   localparam int RANDOM_REQS = 1830;
   localparam int CYCLE_LIMIT = 2500000;

   class id_table_scoreboard;
      bit [31:0]   stored_ids   [DEPTH];
      bit [15:0]   stored_media [DEPTH];
      bit [63:0]   stored_names [DEPTH];
      int unsigned entry_count;
      int unsigned level_hint   [HINTS];
      rsp_type     awaited_answers[$];
      int          mismatch_count;
      int          inserts, dropped, finds, hint_hits, scan_hits, misses;

      function new();
         entry_count = 0;
         foreach (level_hint[i]) level_hint[i] = 0;
      endfunction

      function bit [7:0] fold_char(bit [7:0] c);
         return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
      endfunction

      // characters agree after case folding, up to and including the first zero
      function bit text_equal(bit [63:0] a, bit [63:0] b, int nchars);
         for (int k = 0; k < nchars; k++) begin
            if (fold_char(a[8*k +: 8]) != fold_char(b[8*k +: 8])) return 1'b0;
            if (a[8*k +: 8] == 8'h00) return 1'b1;
         end
         return 1'b1;
      endfunction

      function bit entry_matches(int unsigned slot, bit [15:0] media, bit [63:0] name);
         return text_equal({48'h0, stored_media[slot]}, {48'h0, media}, MEDIA_CHARS) &&
                text_equal(stored_names[slot], name, NAME_LEN);
      endfunction

      function void note_request(req_type r);
         rsp_type     answer;
         int unsigned lvl;
         bit          found;
         answer = '0;
         lvl    = 32'(r.level);
         found  = 1'b0;
         if (r.kind == KIND_INSERT) begin
            inserts++;
            if (entry_count >= DEPTH) begin
               answer.table_full = 1'b1;
               dropped++;
            end else begin
               stored_ids[entry_count]   = r.record_id;
               stored_media[entry_count] = r.media_code;
               stored_names[entry_count] = r.volume_name;
               entry_count++;
               answer.result_id = r.record_id;
            end
         end else begin
            finds++;
            if (entry_count != 0) begin
               if (lvl < HINTS && level_hint[lvl] < entry_count &&
                   entry_matches(level_hint[lvl], r.media_code, r.volume_name)) begin
                  answer.result_id = stored_ids[level_hint[lvl]];
                  found = 1'b1;
                  hint_hits++;
               end
               for (int unsigned s = 0; s < entry_count && !found; s++) begin
                  if (entry_matches(s, r.media_code, r.volume_name)) begin
                     if (lvl < HINTS) level_hint[lvl] = s;
                     answer.result_id = stored_ids[s];
                     found = 1'b1;
                     scan_hits++;
                  end
               end
            end
            if (!found) misses++;
         end
         awaited_answers.push_back(answer);
      endfunction

      function void report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, what);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: id %h full %b",
                                      got.result_id, got.table_full));
            return;
         end
         want = awaited_answers.pop_front();
         if (got.result_id !== want.result_id)
            report_mismatch($sformatf("result_id expected %h got %h",
                                      want.result_id, got.result_id));
         if (got.table_full !== want.table_full)
            report_mismatch($sformatf("table_full expected %b got %b",
                                      want.table_full, got.table_full));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   id_table_scoreboard id_board;
   int      cycle_count = 0;
   string   media_pool[4] = '{"lt", "sg", "ti", "od"};

   name_to_id_lookup_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL name_to_id_lookup_table_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) id_board.check_result(rsp_item);
   end

   // first character lands in bits 7:0
   function automatic bit [63:0] pack_text(string s);
      bit [63:0] v;
      v = '0;
      for (int k = 0; k < s.len() && k < 8; k++) v[8*k +: 8] = s[k];
      return v;
   endfunction

   function automatic req_type make_req(logic kind, int level, bit [15:0] media,
                                        bit [63:0] name, bit [31:0] id);
      req_type r;
      r.kind        = kind;
      r.level       = level[2:0];
      r.media_code  = media;
      r.volume_name = name;
      r.record_id   = id;
      return r;
   endfunction

   function automatic bit [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 8'(8'h80 + $urandom_range(0, 127));
      if (pick < 20) return 8'(8'h30 + $urandom_range(0, 9));
      return 8'(8'h61 + $urandom_range(0, 25) - ($urandom_range(0, 1) ? 8'h20 : 8'h00));
   endfunction

   function automatic bit [63:0] fresh_name();
      bit [63:0] v;
      int        len;
      v   = '0;
      len = $urandom_range(0, NAME_LEN);
      for (int k = 0; k < len; k++) v[8*k +: 8] = random_char();
      if (len < NAME_LEN - 1 && $urandom_range(0, 3) == 0)
         for (int k = len + 1; k < NAME_LEN; k++) v[8*k +: 8] = 8'($urandom);
      return v;
   endfunction

   // random letter case, and sometimes fresh junk past the terminator
   function automatic bit [63:0] vary_text(bit [63:0] t, int nchars);
      bit [63:0] v;
      bit [7:0]  c;
      v = t;
      for (int k = 0; k < nchars; k++) begin
         c = v[8*k +: 8];
         if (c == 8'h00) begin
            if ($urandom_range(0, 2) == 0)
               for (int j = k + 1; j < nchars; j++) v[8*j +: 8] = 8'($urandom);
            break;
         end
         if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) && $urandom_range(0, 1))
            v[8*k + 5] = ~v[8*k + 5];
      end
      return v;
   endfunction

   function automatic bit [15:0] fresh_media();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'(vary_text(pack_text(media_pool[$urandom_range(0, 3)]), MEDIA_CHARS));
   endfunction

   task automatic send_request(req_type r, bit allow_gaps);
      while (allow_gaps && $urandom_range(0, 99) < 37) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      id_board.note_request(r);
   endtask

   task automatic run_directed();
      bit [15:0] lt;
      bit [63:0] abc;
      lt  = 16'(pack_text("lt"));
      abc = pack_text("ABCDEFGH");
      // finds on an empty table
      send_request(make_req(KIND_FIND, 0, lt, abc, 32'h1), 1'b1);
      send_request(make_req(KIND_FIND, 7, 16'hffff, '1, '1), 1'b1);
      // empty names, full-width name, junk after the terminator, all-ones entry
      send_request(make_req(KIND_INSERT, 7, 16'h0, 64'h0, 32'h0), 1'b1);
      send_request(make_req(KIND_INSERT, 0, 16'(pack_text("LT")), abc, 32'hffff_ffff), 1'b1);
      send_request(make_req(KIND_INSERT, 3, lt, pack_text("vol1") | 64'h5a5a_0000_0000_0000,
                            32'h1234_5678), 1'b1);
      send_request(make_req(KIND_INSERT, 5, 16'hffff, '1, 32'h8000_0001), 1'b1);
      // duplicate in other case, a later slot that a find must never answer
      send_request(make_req(KIND_INSERT, 1, 16'(pack_text("Lt")), pack_text("abcdefgh"),
                            32'h0000_dead), 1'b1);
      // letters next to the a..z / A..Z ranges must not fold
      send_request(make_req(KIND_INSERT, 2, 16'(pack_text("od")), pack_text("@[Z"),
                            32'h55aa_55aa), 1'b1);
      // level hint misses then scan, then the same level hits its hint
      send_request(make_req(KIND_FIND, 0, lt, pack_text("abcdefgh"), 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 0, 16'(pack_text("LT")), pack_text("AbCdEfGh"), '1), 1'b1);
      send_request(make_req(KIND_FIND, 1, 16'(pack_text("lT")),
                            pack_text("VOL1") | 64'h0011_2233_0000_0000, 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 2, 16'h0, 64'h0, 32'h0), 1'b1);
      // media and name whose first character is zero, junk behind it
      send_request(make_req(KIND_FIND, 3, 16'hab00, 64'hffee_ddcc_bbaa_9900, 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 4, 16'hffff, '1, 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 5, lt, pack_text("abcdefgi"), 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 6, lt, abc, 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 7, lt, pack_text("abcdefg"), 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 1, 16'(pack_text("od")), pack_text("`{z"), 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 1, 16'(pack_text("OD")), pack_text("@[z"), 32'h0), 1'b1);
      send_request(make_req(KIND_FIND, 1, 16'(pack_text("od")), pack_text("@[Z"), 32'h0), 1'b0);
   endtask

   task automatic run_random();
      req_type     r;
      req_type     last_find [8];
      int          pick;
      int          lvl;
      int unsigned slot;
      bit          gaps;
      for (int k = 0; k < 8; k++) last_find[k] = make_req(KIND_FIND, k, 16'h0, 64'h0, 32'h0);
      for (int i = 0; i < RANDOM_REQS; i++) begin
         gaps = !(i >= 700 && i < 950);
         lvl  = $urandom_range(0, 7);
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               r = make_req(KIND_INSERT, lvl, 16'($urandom), {$urandom, $urandom}, $urandom);
            end else if (pick < 25 && id_board.entry_count != 0) begin
               slot = $urandom_range(0, id_board.entry_count - 1);
               r = make_req(KIND_INSERT, lvl, 16'(vary_text({48'h0, id_board.stored_media[slot]},
                            MEDIA_CHARS)), vary_text(id_board.stored_names[slot], NAME_LEN),
                            $urandom);
            end else begin
               r = make_req(KIND_INSERT, lvl, fresh_media(), fresh_name(), $urandom);
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10 || id_board.entry_count == 0) begin
               r = make_req(KIND_FIND, lvl, 16'($urandom), {$urandom, $urandom}, $urandom);
            end else if (pick < 30) begin
               // same query again at its level, so the hint gets exercised
               r = last_find[lvl];
               r.media_code  = 16'(vary_text({48'h0, r.media_code}, MEDIA_CHARS));
               r.volume_name = vary_text(r.volume_name, NAME_LEN);
               r.record_id   = $urandom;
            end else begin
               slot = $urandom_range(0, id_board.entry_count - 1);
               r = make_req(KIND_FIND, lvl, 16'(vary_text({48'h0, id_board.stored_media[slot]},
                            MEDIA_CHARS)), vary_text(id_board.stored_names[slot], NAME_LEN),
                            $urandom);
               // near miss: one bit off somewhere
               if (pick >= 90) r.volume_name[6'($urandom_range(0, 63))] ^= 1'b1;
            end
            last_find[lvl] = r;
         end
         send_request(r, gaps);
      end
   endtask

   initial begin
      id_board = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random();
      @(negedge clock);
      start <= 1'b0;

      while (id_board.awaited_answers.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      $display("%0d requests: %0d inserts (%0d dropped on a full table), %0d finds",
               id_board.inserts + id_board.finds, id_board.inserts, id_board.dropped,
               id_board.finds);
      $display("finds answered by level hint %0d, by scan %0d, not found %0d; mismatches %0d",
               id_board.hint_hits, id_board.scan_hits, id_board.misses,
               id_board.mismatch_count);
      if (id_board.mismatch_count == 0 && id_board.awaited_answers.size() == 0) begin
         $display("PASS name_to_id_lookup_table_unit");
      end else begin
         $display("FAIL name_to_id_lookup_table_unit");
      end
      $finish;
   end

endmodule
